### rtl/deep_sample_flatten_under_top_defines.svh
// assertion macros for the deep sample flattener
// used by the top level only, no other dependencies
`ifndef DEEP_SAMPLE_FLATTEN_UNDER_TOP_DEFINES_SVH
`define DEEP_SAMPLE_FLATTEN_UNDER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DSFU_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DSFU_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dsfu_pkg.sv
// types, constants and arithmetic helpers for the deep sample flattener
// no dependencies
`default_nettype none

package dsfu_pkg;

  localparam int CHANNELS    = 8;
  localparam int FRAC_BITS   = 12;
  localparam int DATA_W      = 16;
  localparam int SLOT_W      = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int WEIGHT_W    = DATA_W + 2;
  localparam int MUL_W       = DATA_W + WEIGHT_W;
  localparam int WIDE_W      = MUL_W + 2;

  typedef logic signed [DATA_W-1:0]   fx_t;
  typedef logic signed [SLOT_W-1:0]   slot_t;
  typedef logic signed [WEIGHT_W-1:0] wt_t;
  typedef logic signed [MUL_W-1:0]    mul_t;
  typedef logic signed [WIDE_W-1:0]   wide_t;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_RED   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_GREEN = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_BLUE  = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA = CFG_INDEX_W'(3);

  // register reset values
  localparam slot_t RST_RED_SLOT   = slot_t'(0);
  localparam slot_t RST_GREEN_SLOT = slot_t'(1);
  localparam slot_t RST_BLUE_SLOT  = slot_t'(2);
  localparam slot_t RST_ALPHA_SLOT = slot_t'(3);

  localparam fx_t   ONE_FX  = fx_t'(2 ** FRAC_BITS);
  localparam fx_t   ZERO_FX = fx_t'(0);
  localparam fx_t   FX_MAX  = fx_t'(32767);
  localparam fx_t   FX_MIN  = fx_t'(-32768);
  localparam wide_t FX_MAX_W = wide_t'(32767);
  localparam wide_t FX_MIN_W = wide_t'(-32768);
  localparam wide_t HALF_W   = wide_t'(2 ** (FRAC_BITS - 1));

  typedef struct packed {
    fx_t  chan0;
    fx_t  chan1;
    fx_t  chan2;
    fx_t  chan3;
    fx_t  chan4;
    fx_t  chan5;
    fx_t  chan6;
    fx_t  chan7;
    logic last_sample;
    logic empty_pixel;
  } sample_t;

  typedef struct packed {
    fx_t red;
    fx_t green;
    fx_t blue;
    fx_t alpha;
  } pixel_t;

  // classified sample handed from front to back
  typedef struct packed {
    fx_t  sr;
    fx_t  sg;
    fx_t  sb;
    fx_t  sa;
    logic last_sample;
    logic empty_pixel;
  } work_t;

  // saturate a wide sum to 16 bits signed
  function automatic fx_t sat16(wide_t v);
    fx_t r;
    if (v > FX_MAX_W) begin
      r = FX_MAX;
    end else if (v < FX_MIN_W) begin
      r = FX_MIN;
    end else begin
      r = fx_t'(v[DATA_W-1:0]);
    end
    return r;
  endfunction

  // s * w / 2^frac, round to nearest with ties toward plus infinity
  function automatic wide_t scale_term(fx_t s, wt_t w);
    mul_t  m;
    wide_t p;
    m = mul_t'(s) * mul_t'(w);
    p = wide_t'(m) + HALF_W;
    return p >>> FRAC_BITS;
  endfunction

  // channel value in a slot, or the default when the slot is absent
  function automatic fx_t pick(sample_t it, slot_t slot, fx_t dflt);
    fx_t ch [8];
    fx_t r;
    ch[0] = it.chan0;
    ch[1] = it.chan1;
    ch[2] = it.chan2;
    ch[3] = it.chan3;
    ch[4] = it.chan4;
    ch[5] = it.chan5;
    ch[6] = it.chan6;
    ch[7] = it.chan7;
    if (slot < slot_t'(0) || int'(slot) >= CHANNELS) begin
      r = dflt;
    end else begin
      r = ch[slot[SLOT_W-2:0]];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/dsfu_sample_if.sv
// sample input channel: valid, ready and one deep sample
// depends on dsfu_pkg
`default_nettype none

interface dsfu_sample_if;
  logic              valid;
  logic              ready;
  dsfu_pkg::sample_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/dsfu_pixel_if.sv
// pixel output channel: valid, ready and one flattened rgba result
// depends on dsfu_pkg
`default_nettype none

interface dsfu_pixel_if;
  logic             valid;
  logic             ready;
  dsfu_pkg::pixel_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/dsfu_queue.sv
// short fifo between the classifying front and the compositing back
// depends on dsfu_pkg
`default_nettype none

module dsfu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dsfu_pkg::work_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output dsfu_pkg::work_t out_data
);
  import dsfu_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  work_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              wr_en;
  logic              rd_en;

  assign in_ready  = (count != CNT_W'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign wr_en     = in_valid && in_ready;
  assign rd_en     = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  // storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= in_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/dsfu_front.sv
// front end: channel slot registers and rgba selection of each sample
// depends on dsfu_pkg and dsfu_sample_if
`default_nettype none

module dsfu_front (
  input  logic                                clk,
  input  logic                                rst,
  dsfu_sample_if.sink                         samples,
  input  logic                                cfg_we,
  input  logic [dsfu_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dsfu_pkg::SLOT_W-1:0]         cfg_data,
  output logic                                push_valid,
  input  logic                                push_ready,
  output dsfu_pkg::work_t                     push_data
);
  import dsfu_pkg::*;

  slot_t red_slot;
  slot_t green_slot;
  slot_t blue_slot;
  slot_t alpha_slot;

  // channel slot registers
  always_ff @(posedge clk) begin
    if (rst) begin
      red_slot   <= RST_RED_SLOT;
      green_slot <= RST_GREEN_SLOT;
      blue_slot  <= RST_BLUE_SLOT;
      alpha_slot <= RST_ALPHA_SLOT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RED:   red_slot   <= slot_t'(cfg_data);
        REG_GREEN: green_slot <= slot_t'(cfg_data);
        REG_BLUE:  blue_slot  <= slot_t'(cfg_data);
        REG_ALPHA: alpha_slot <= slot_t'(cfg_data);
      endcase
    end
  end

  // pick rgba out of the sample, absent alpha is opaque
  always_comb begin
    push_data.sr          = pick(samples.payload, red_slot, ZERO_FX);
    push_data.sg          = pick(samples.payload, green_slot, ZERO_FX);
    push_data.sb          = pick(samples.payload, blue_slot, ZERO_FX);
    push_data.sa          = pick(samples.payload, alpha_slot, ONE_FX);
    push_data.last_sample = samples.payload.last_sample;
    push_data.empty_pixel = samples.payload.empty_pixel;
  end

  assign push_valid    = samples.valid;
  assign samples.ready = push_ready;

endmodule

`default_nettype wire

### rtl/dsfu_back.sv
// back end: under-compositing accumulators and the registered pixel output
// depends on dsfu_pkg and dsfu_pixel_if
`default_nettype none

module dsfu_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  dsfu_pkg::work_t q_data,
  dsfu_pixel_if.source    pixels
);
  import dsfu_pkg::*;

  fx_t    acc_red;
  fx_t    acc_green;
  fx_t    acc_blue;
  fx_t    acc_alpha;
  logic   opaque_reached;
  logic   out_valid;
  pixel_t out_data;

  wt_t    weight;
  fx_t    red_sum;
  fx_t    green_sum;
  fx_t    blue_sum;
  fx_t    alpha_sum;
  logic   alpha_hit;
  pixel_t upd;
  logic   emit;
  logic   pop;

  // one multiply-add per channel against the remaining transparency
  always_comb begin
    weight    = wt_t'(ONE_FX) - wt_t'(acc_alpha);
    red_sum   = sat16(wide_t'(acc_red) + scale_term(q_data.sr, weight));
    green_sum = sat16(wide_t'(acc_green) + scale_term(q_data.sg, weight));
    blue_sum  = sat16(wide_t'(acc_blue) + scale_term(q_data.sb, weight));
    alpha_sum = sat16(wide_t'(acc_alpha) + scale_term(q_data.sa, weight));
    alpha_hit = (alpha_sum >= ONE_FX);
    if (opaque_reached) begin
      upd.red   = acc_red;
      upd.green = acc_green;
      upd.blue  = acc_blue;
      upd.alpha = acc_alpha;
    end else begin
      upd.red   = red_sum;
      upd.green = green_sum;
      upd.blue  = blue_sum;
      upd.alpha = alpha_hit ? ONE_FX : alpha_sum;
    end
  end

  // take from the queue unless a result would overrun a stalled output
  assign emit    = q_data.last_sample || q_data.empty_pixel;
  assign q_ready = !emit || !out_valid || pixels.ready;
  assign pop     = q_valid && q_ready;

  // accumulators and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_red        <= ZERO_FX;
      acc_green      <= ZERO_FX;
      acc_blue       <= ZERO_FX;
      acc_alpha      <= ZERO_FX;
      opaque_reached <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && pixels.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (emit) begin
          acc_red        <= ZERO_FX;
          acc_green      <= ZERO_FX;
          acc_blue       <= ZERO_FX;
          acc_alpha      <= ZERO_FX;
          opaque_reached <= 1'b0;
          out_valid      <= 1'b1;
        end else begin
          acc_red        <= upd.red;
          acc_green      <= upd.green;
          acc_blue       <= upd.blue;
          acc_alpha      <= upd.alpha;
          opaque_reached <= opaque_reached || alpha_hit;
        end
      end
    end
  end

  // result register, empty pixel gives transparent black
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      if (q_data.empty_pixel) begin
        out_data <= '0;
      end else begin
        out_data <= upd;
      end
    end
  end

  assign pixels.valid   = out_valid;
  assign pixels.payload = out_data;

endmodule

`default_nettype wire

### rtl/deep_sample_flatten_under_top.sv
// Deep pixel flattener. Samples of one pixel arrive front to back, one per
// transfer, and are folded in with the under operator; the last sample or an
// empty-pixel item releases one saturated Q3.12 RGBA result. A new sample is
// taken every clock cycle while the queue has room, the rate set by the
// accumulator update in the back end (one multiply-add per channel, alpha
// feeding the weight of the next sample). A result is presented through a
// two-entry queue and a registered output; a stalled output holds back only
// items that would produce a result until the queue fills. No clearing pass
// after reset. The user writes slot registers through cfg_we/cfg_index/
// cfg_data only while the block is idle; the block does not enforce this.
// depends on dsfu_pkg, the channel interfaces, front, queue and back
`default_nettype none

`include "deep_sample_flatten_under_top_defines.svh"

module deep_sample_flatten_under_top (
  input  logic                              clk,
  input  logic                              rst,
  dsfu_sample_if.sink                       samples,
  dsfu_pixel_if.source                      pixels,
  input  logic                              cfg_we,
  input  logic [dsfu_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dsfu_pkg::SLOT_W-1:0]       cfg_data
);
  import dsfu_pkg::*;

  logic  push_valid;
  logic  push_ready;
  work_t push_data;
  logic  q_valid;
  logic  q_ready;
  work_t q_data;

  // classify samples
  dsfu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decouple front and back
  dsfu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   (push_data),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  // composite and emit
  dsfu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data),
    .pixels  (pixels)
  );

  // checks
  `DSFU_ASSERT_IMPLY(a_alpha_clamped, clk, rst, pixels.valid, pixels.payload.alpha <= ONE_FX, "flattened alpha above one")
  `DSFU_ASSERT_NEXT(a_empty_emits, clk, rst, q_valid && q_ready && q_data.empty_pixel, pixels.valid && pixels.payload.alpha == ZERO_FX, "empty pixel did not give transparent black")
  `DSFU_ASSERT_IMPLY(a_no_overrun, clk, rst, pixels.valid && !pixels.ready && (q_data.last_sample || q_data.empty_pixel), !q_ready, "result item taken while output stalled")

endmodule

`default_nettype wire

### verif/deep_sample_flatten_under_top_tb.sv
// testbench for the deep sample flattener: drives deep samples, checks rgba pixels
// against an in-bench under-compositing predictor, rewrites slot registers between phases
// depends on dsfu_pkg, dsfu_sample_if, dsfu_pixel_if and deep_sample_flatten_under_top
`default_nettype none

module deep_sample_flatten_under_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsfu_pkg::*;

  localparam int     DRAIN_CYCLES  = 8;
  localparam int     RANDOM_PHASES = 6;
  localparam int     PHASE_ITEMS   = 175;
  localparam longint ROUND_HALF    = longint'(1) << (FRAC_BITS - 1);
  localparam longint ONE_L         = longint'(1) << FRAC_BITS;

  typedef logic [0:CHANNELS-1][DATA_W-1:0] chan_vec_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [SLOT_W-1:0]      cfg_data;

  dsfu_sample_if smp_if ();
  dsfu_pixel_if  pix_if ();

  deep_sample_flatten_under_top u_top (
    .clk       (clk),
    .rst       (rst),
    .samples   (smp_if),
    .pixels    (pix_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state: slot selects and under accumulators
  slot_t  slot_sel [4];
  fx_t    acc_r;
  fx_t    acc_g;
  fx_t    acc_b;
  fx_t    acc_a;
  bit     opaque;
  pixel_t pending_pixels [$];
  int     failures;

  // sender burst state
  int burst_left;

  // receiver stall state
  int     rx_mode;
  int     rx_mode_left;
  int     rx_stall_left;
  int     rx_cycle;
  pixel_t want;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // acc + s * w scaled back, rounded half up, saturated to 16 bits
  function automatic fx_t under_add(fx_t acc, fx_t s, longint w);
    longint sum;
    sum = longint'(acc) + ((longint'(s) * w + ROUND_HALF) >>> FRAC_BITS);
    if (sum > 32767) begin
      return fx_t'(16'sh7fff);
    end else if (sum < -32768) begin
      return fx_t'(16'sh8000);
    end
    return fx_t'(sum);
  endfunction

  // channel in the selected slot, default when the slot is absent
  function automatic fx_t slot_value(chan_vec_t cv, slot_t slot, fx_t dflt);
    if (slot < 0 || int'(slot) >= CHANNELS) begin
      return dflt;
    end
    return fx_t'(cv[int'(slot)]);
  endfunction

  task automatic clear_pixel();
    acc_r  = '0;
    acc_g  = '0;
    acc_b  = '0;
    acc_a  = '0;
    opaque = 1'b0;
  endtask

  // fold one accepted sample into the pixel, queue the rgba result if one is due
  task automatic fold_sample(input sample_t s);
    chan_vec_t cv;
    pixel_t    px;
    longint    w;
    if (s.empty_pixel) begin
      clear_pixel();
      pending_pixels.push_back('0);
      return;
    end
    if (!opaque) begin
      cv = {s.chan0, s.chan1, s.chan2, s.chan3, s.chan4, s.chan5, s.chan6, s.chan7};
      w  = ONE_L - longint'(acc_a);
      acc_r = under_add(acc_r, slot_value(cv, slot_sel[REG_RED], ZERO_FX), w);
      acc_g = under_add(acc_g, slot_value(cv, slot_sel[REG_GREEN], ZERO_FX), w);
      acc_b = under_add(acc_b, slot_value(cv, slot_sel[REG_BLUE], ZERO_FX), w);
      acc_a = under_add(acc_a, slot_value(cv, slot_sel[REG_ALPHA], ONE_FX), w);
      if (acc_a >= ONE_FX) begin
        acc_a  = ONE_FX;
        opaque = 1'b1;
      end
    end
    if (s.last_sample) begin
      px.red   = acc_r;
      px.green = acc_g;
      px.blue  = acc_b;
      px.alpha = acc_a;
      pending_pixels.push_back(px);
      clear_pixel();
    end
  endtask

  // one sample transfer, with random bursts and gaps on the sender side
  task automatic send_sample(input chan_vec_t cv, input bit last, input bit empty);
    sample_t s;
    int      gap;
    s = sample_t'({cv, last, empty});
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        smp_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    smp_if.valid   <= 1'b1;
    smp_if.payload <= s;
    @(posedge clk);
    while (!smp_if.ready) @(posedge clk);
    fold_sample(s);
  endtask

  // stop sending and let every expected pixel and any trailing work drain
  task automatic wait_idle();
    smp_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all four slot registers back to back, block idle
  task automatic set_slots(input slot_t r, input slot_t g, input slot_t b, input slot_t a);
    slot_t vals [4];
    vals[REG_RED]   = r;
    vals[REG_GREEN] = g;
    vals[REG_BLUE]  = b;
    vals[REG_ALPHA] = a;
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_INDEX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      slot_sel[i] = vals[i];
    end
    cfg_we <= 1'b0;
  endtask

  // random channel value, alpha slot biased so pixels take several samples
  function automatic fx_t rand_value(bit for_alpha);
    int kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      case ($urandom_range(0, 4))
        0:       return fx_t'(16'sh8000);
        1:       return fx_t'(16'sh7fff);
        2:       return ZERO_FX;
        3:       return fx_t'(-1);
        default: return ONE_FX;
      endcase
    end
    if (kind == 1) begin
      return fx_t'($urandom());
    end
    if (for_alpha) begin
      if (kind == 2) return fx_t'(int'($urandom_range(0, 2048)) - 2048);
      if (kind == 3) return fx_t'($urandom_range(4096, 12000));
      return fx_t'($urandom_range(0, 1600));
    end
    if (kind < 6) return fx_t'(int'($urandom_range(0, 12288)) - 4096);
    return fx_t'($urandom());
  endfunction

  // random pixels: mostly well-formed runs ending in a last mark, some empty items
  task automatic send_random_pixels(input int n_items);
    chan_vec_t cv;
    int        sent;
    int        len;
    bit        empty;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      for (int j = 0; j < len && sent < n_items; j++) begin
        for (int i = 0; i < CHANNELS; i++) begin
          cv[i] = rand_value(slot_sel[REG_ALPHA] == i);
        end
        empty = ($urandom_range(0, 24) == 0);
        send_sample(cv, (j == len - 1) ? 1'b1 : 1'($urandom_range(0, 1) & empty), empty);
        sent++;
      end
    end
  endtask

  // full-scale positive, full-scale negative, zero and one-lsb single-sample pixels
  task automatic test_extremes();
    send_sample({CHANNELS{16'h7fff}}, 1'b1, 1'b0);
    send_sample({CHANNELS{16'h8000}}, 1'b1, 1'b0);
    send_sample({CHANNELS{16'h0000}}, 1'b1, 1'b0);
    send_sample({CHANNELS{16'h0001}}, 1'b1, 1'b0);
  endtask

  // several partial-alpha samples accumulate into one pixel
  task automatic test_accumulation();
    chan_vec_t cv;
    cv    = {CHANNELS{16'h0555}};
    cv[3] = 16'h0800;
    send_sample(cv, 1'b0, 1'b0);
    cv[0] = 16'hf123;
    send_sample(cv, 1'b0, 1'b0);
    cv[3] = 16'h0400;
    send_sample(cv, 1'b1, 1'b0);
  endtask

  // once alpha hits one the rest of the pixel is ignored
  task automatic test_opaque_hold();
    chan_vec_t cv;
    cv    = {CHANNELS{16'h0200}};
    cv[3] = ONE_FX;
    send_sample(cv, 1'b0, 1'b0);
    send_sample({CHANNELS{16'h7fff}}, 1'b0, 1'b0);
    send_sample({CHANNELS{16'h8000}}, 1'b1, 1'b0);
  endtask

  // negative alpha pushes the weight above one and the sums saturate
  task automatic test_negative_alpha();
    chan_vec_t cv;
    cv    = {CHANNELS{16'h7fff}};
    cv[3] = 16'h8000;
    send_sample(cv, 1'b0, 1'b0);
    cv[3] = 16'h7fff;
    send_sample(cv, 1'b1, 1'b0);
  endtask

  // empty pixel wins over last and discards a partly built pixel
  task automatic test_empty_pixel();
    chan_vec_t cv;
    cv    = {CHANNELS{16'h0300}};
    cv[3] = 16'h0200;
    send_sample(cv, 1'b0, 1'b0);
    send_sample({CHANNELS{16'h7fff}}, 1'b1, 1'b1);
    send_sample({CHANNELS{16'h8000}}, 1'b0, 1'b1);
    send_sample(cv, 1'b1, 1'b0);
  endtask

  // absent color reads zero, absent alpha reads one, top slot selects
  task automatic test_absent_slots();
    chan_vec_t cv;
    set_slots(slot_t'(7), slot_t'(-1), slot_t'(-8), slot_t'(-1));
    cv    = {CHANNELS{16'h0444}};
    cv[7] = 16'h0c00;
    send_sample(cv, 1'b1, 1'b0);
    set_slots(slot_t'(-1), slot_t'(4), slot_t'(-1), slot_t'(7));
    cv[7] = 16'h0400;
    send_sample(cv, 1'b0, 1'b0);
    send_sample(cv, 1'b1, 1'b0);
  endtask

  // random pixels under a series of slot settings
  task automatic test_random_phases();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       set_slots(RST_RED_SLOT, RST_GREEN_SLOT, RST_BLUE_SLOT, RST_ALPHA_SLOT);
        1:       set_slots(slot_t'(7), slot_t'(6), slot_t'(5), slot_t'(4));
        2:       set_slots(slot_t'(-1), slot_t'(-1), slot_t'(-1), slot_t'(-1));
        3:       set_slots(slot_t'(3), slot_t'(3), slot_t'(3), slot_t'(3));
        4:       set_slots(slot_t'(-8), slot_t'(7), slot_t'(0), slot_t'(-8));
        default: set_slots(slot_t'($urandom_range(0, 15)), slot_t'($urandom_range(0, 15)),
                           slot_t'($urandom_range(0, 15)), slot_t'($urandom_range(0, 7)));
      endcase
      send_random_pixels(PHASE_ITEMS);
    end
  endtask

  // receiver: ready follows a randomly chosen mode, redrawn whenever the current one runs out
  always @(posedge clk) begin
    if (rst) begin
      pix_if.ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(32, 200);
      end
      rx_mode_left--;
      rx_cycle++;
      case (rx_mode)
        0: pix_if.ready <= 1'b1;
        1: pix_if.ready <= ($urandom_range(0, 9) < 7);
        2: pix_if.ready <= (rx_cycle % 4 != 0);
        default: begin
          if (rx_stall_left > 0) begin
            rx_stall_left--;
            pix_if.ready <= 1'b0;
          end else begin
            pix_if.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) rx_stall_left = $urandom_range(1, 25);
          end
        end
      endcase
    end
  end

  task automatic check_field(input string name, input fx_t exp_v, input fx_t got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      failures++;
    end
  endtask

  // compare each pixel transfer with the oldest expected pixel
  always @(posedge clk) begin
    if (!rst && pix_if.valid && pix_if.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel transfer with none expected: r %0d g %0d b %0d a %0d",
               pix_if.payload.red, pix_if.payload.green, pix_if.payload.blue,
               pix_if.payload.alpha);
        failures++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("red", want.red, pix_if.payload.red);
        check_field("green", want.green, pix_if.payload.green);
        check_field("blue", want.blue, pix_if.payload.blue);
        check_field("alpha", want.alpha, pix_if.payload.alpha);
      end
    end
  end

  // main sequence
  initial begin
    burst_left    = 0;
    slot_sel[REG_RED]   = RST_RED_SLOT;
    slot_sel[REG_GREEN] = RST_GREEN_SLOT;
    slot_sel[REG_BLUE]  = RST_BLUE_SLOT;
    slot_sel[REG_ALPHA] = RST_ALPHA_SLOT;
    clear_pixel();
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    smp_if.valid   <= 1'b0;
    smp_if.payload <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_accumulation();
    test_opaque_hold();
    test_negative_alpha();
    test_empty_pixel();
    test_absent_slots();
    test_random_phases();

    wait_idle();
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
